@@ rtl/kcat_pkg.sv @@
// Shared types, codes and helpers for the keyed case aggregation table.
package kcat_pkg;

    localparam int CITY_W  = 24;
    localparam int STATE_W = 7;
    localparam int CNT_W   = 32;
    localparam int SUM_W   = 48;
    localparam int DATE_W  = 32;
    localparam int KIND_W  = 3;
    localparam int FILL_W  = 6;

    // Sequencer states, also broadcast to the cells as the pass mode.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADD  = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;
    localparam logic [1:0] ST_ROWS = 2'd3;

    localparam logic [KIND_W-1:0] KIND_INSERTED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MERGED   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FULL     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TOTAL    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ROW      = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NOTFOUND = 3'd5;

    localparam logic ACT_ADD = 1'b0;

    typedef struct packed {
        logic [CITY_W-1:0]  city;
        logic [STATE_W-1:0] state;
        logic [CNT_W-1:0]   cases;
        logic [DATE_W-1:0]  date;
    } t_req;

    // Token that walks down the row of cells.
    typedef struct packed {
        logic              act;
        logic              hit;
        logic [SUM_W-1:0]  sum;
        logic [FILL_W-1:0] cnt;
    } t_tok;

    // Entry offered by a cell in the cycle the token visits it.
    typedef struct packed {
        logic               hit;
        logic [CITY_W-1:0]  city;
        logic [STATE_W-1:0] state;
        logic [SUM_W-1:0]   cases;
        logic [DATE_W-1:0]  date;
    } t_sel;

    function automatic logic [SUM_W-1:0] sat_add48(input logic [SUM_W-1:0] a,
                                                   input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

@@ rtl/kcat_cell.sv @@
// One table entry plus its stage of the walking token.
module kcat_cell
    import kcat_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [1:0] i_mode,
    input  t_req       i_req,
    input  logic       i_valid,
    input  logic       i_wr,
    input  t_tok       i_tok,
    output t_tok       o_tok,
    output t_sel       o_sel
);

    logic [CITY_W-1:0]  r_city;
    logic [STATE_W-1:0] r_state;
    logic [SUM_W-1:0]   r_cases;
    logic [DATE_W-1:0]  r_date;
    t_tok               r_tok;
    t_tok               n_tok;

    logic               state_m;
    logic               key_m;
    logic               add_hit;
    logic               row_hit;
    logic               sel_hit;
    logic [SUM_W-1:0]   new_cases;
    logic [DATE_W-1:0]  new_date;

    assign state_m   = (r_state == i_req.state);
    assign key_m     = state_m && (r_city == i_req.city);
    assign add_hit   = i_tok.act && i_valid && (i_mode == ST_ADD) && !i_tok.hit && key_m;
    assign row_hit   = i_tok.act && i_valid && state_m;
    assign sel_hit   = add_hit | ((i_mode == ST_ROWS) && row_hit);
    assign new_cases = sat_add48(r_cases, {{(SUM_W-CNT_W){1'b0}}, i_req.cases});
    assign new_date  = (i_req.date >= r_date) ? i_req.date : r_date;

    always_comb begin
        n_tok = i_tok;
        unique case (i_mode)
            ST_ADD: begin
                n_tok.hit = i_tok.hit | add_hit;
            end
            ST_SUM: begin
                if (row_hit) begin
                    n_tok.sum = sat_add48(i_tok.sum, r_cases);
                    n_tok.cnt = i_tok.cnt + FILL_W'(1);
                end
            end
            ST_ROWS: begin
                n_tok = i_tok;
            end
            default: begin
                n_tok.act = 1'b0;
            end
        endcase
    end

    // Offer nothing unless this cell holds the token and hits, so the OR stays clean.
    always_comb begin
        o_sel.hit   = sel_hit;
        o_sel.city  = sel_hit ? r_city : '0;
        o_sel.state = sel_hit ? r_state : '0;
        o_sel.cases = sel_hit ? (add_hit ? new_cases : r_cases) : '0;
        o_sel.date  = sel_hit ? (add_hit ? new_date : r_date) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_city  <= i_req.city;
            r_state <= i_req.state;
            r_cases <= {{(SUM_W-CNT_W){1'b0}}, i_req.cases};
            r_date  <= i_req.date;
        end else if (add_hit) begin
            r_cases <= new_cases;
            r_date  <= new_date;
        end
    end

    assign o_tok = r_tok;

endmodule

@@ rtl/keyed_case_aggregation_table_top.sv @@
// Top level: sequencer and result register around a row of table cells.
//
//  channel  | handshake      | payload
//  ---------+----------------+-----------------------------------------------
//  request  | start / busy   | i_action i_city_code i_state_code i_case_count
//           |                | i_record_date
//  result   | o_valid strobe | o_kind o_out_city o_out_state o_case_total
//           |                | o_latest_date o_last
//
// A token walks the cell row one cell per cycle. An add request, or a report
// with no matching entry, returns to idle once the token leaves the last cell;
// start is taken only while idle, so a new request waits for busy to fall. A
// report with matches makes a second pass for the rows before it returns to idle.
// Reset empties the table at once (fill count to zero). Each result is
// shown for one cycle under o_valid; the receiver cannot stall it.
module keyed_case_aggregation_table_top
    import kcat_pkg::*;
#(
    parameter int ENTRIES = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_action,
    input  logic [CITY_W-1:0]  i_city_code,
    input  logic [STATE_W-1:0] i_state_code,
    input  logic [CNT_W-1:0]   i_case_count,
    input  logic [DATE_W-1:0]  i_record_date,
    output logic               o_valid,
    output logic [KIND_W-1:0]  o_kind,
    output logic [CITY_W-1:0]  o_out_city,
    output logic [STATE_W-1:0] o_out_state,
    output logic [SUM_W-1:0]   o_case_total,
    output logic [DATE_W-1:0]  o_latest_date,
    output logic               o_last
);

    logic [1:0]        r_fsm,    n_fsm;
    t_req              r_req,    n_req;
    logic              r_launch, n_launch;
    logic [FILL_W-1:0] r_fill,   n_fill;
    logic [FILL_W-1:0] r_count,  n_count;
    logic [FILL_W-1:0] r_emit,   n_emit;

    logic               r_valid, n_valid;
    logic [KIND_W-1:0]  r_kind,  n_kind;
    logic [CITY_W-1:0]  r_city,  n_city;
    logic [STATE_W-1:0] r_state, n_state;
    logic [SUM_W-1:0]   r_total, n_total;
    logic [DATE_W-1:0]  r_date,  n_date;
    logic               r_last,  n_last;

    t_tok               head_tok;
    t_tok               tail;
    t_tok               w_tok [ENTRIES];
    t_sel               w_sel [ENTRIES];
    t_sel               sel_any;
    logic [ENTRIES-1:0] w_valid;
    logic [ENTRIES-1:0] w_wr;
    logic               do_insert;

    assign head_tok = '{act: r_launch, hit: 1'b0, sum: '0, cnt: '0};
    assign tail     = w_tok[ENTRIES-1];

    always_comb begin
        for (int k = 0; k < ENTRIES; k++) begin
            w_valid[k] = FILL_W'(k) < r_fill;
            w_wr[k]    = do_insert && (FILL_W'(k) == r_fill);
        end
    end

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        kcat_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_mode  (r_fsm),
            .i_req   (r_req),
            .i_valid (w_valid[g]),
            .i_wr    (w_wr[g]),
            .i_tok   ((g == 0) ? head_tok : w_tok[(g == 0) ? 0 : g - 1]),
            .o_tok   (w_tok[g]),
            .o_sel   (w_sel[g])
        );
    end

    // Only the cell under the token can offer an entry, so OR them together.
    always_comb begin
        sel_any = '0;
        for (int k = 0; k < ENTRIES; k++) begin
            sel_any = t_sel'(sel_any | w_sel[k]);
        end
    end

    always_comb begin
        n_fsm     = r_fsm;
        n_req     = r_req;
        n_launch  = 1'b0;
        n_fill    = r_fill;
        n_count   = r_count;
        n_emit    = r_emit;
        n_valid   = 1'b0;
        n_kind    = r_kind;
        n_city    = r_city;
        n_state   = r_state;
        n_total   = r_total;
        n_date    = r_date;
        n_last    = r_last;
        do_insert = 1'b0;

        unique case (r_fsm)
            ST_IDLE: begin
                if (start) begin
                    n_req    = '{city: i_city_code, state: i_state_code,
                                 cases: i_case_count, date: i_record_date};
                    n_fsm    = (i_action == ACT_ADD) ? ST_ADD : ST_SUM;
                    n_launch = 1'b1;
                end
            end
            ST_ADD: begin
                if (sel_any.hit) begin
                    n_valid = 1'b1;
                    n_kind  = KIND_MERGED;
                    n_city  = sel_any.city;
                    n_state = sel_any.state;
                    n_total = sel_any.cases;
                    n_date  = sel_any.date;
                    n_last  = 1'b1;
                end
                if (tail.act) begin
                    n_fsm = ST_IDLE;
                    if (!tail.hit) begin
                        n_valid = 1'b1;
                        n_city  = r_req.city;
                        n_state = r_req.state;
                        n_total = {{(SUM_W-CNT_W){1'b0}}, r_req.cases};
                        n_date  = r_req.date;
                        n_last  = 1'b1;
                        if (r_fill < FILL_W'(ENTRIES)) begin
                            do_insert = 1'b1;
                            n_fill    = r_fill + FILL_W'(1);
                            n_kind    = KIND_INSERTED;
                        end else begin
                            n_kind = KIND_FULL;
                        end
                    end
                end
            end
            ST_SUM: begin
                if (tail.act) begin
                    n_valid = 1'b1;
                    n_city  = '0;
                    n_state = r_req.state;
                    n_total = tail.sum;
                    n_date  = '0;
                    if (tail.cnt == '0) begin
                        n_kind = KIND_NOTFOUND;
                        n_last = 1'b1;
                        n_fsm  = ST_IDLE;
                    end else begin
                        // Total goes out now; relaunch the token for the rows.
                        n_kind   = KIND_TOTAL;
                        n_last   = 1'b0;
                        n_count  = tail.cnt;
                        n_emit   = '0;
                        n_launch = 1'b1;
                        n_fsm    = ST_ROWS;
                    end
                end
            end
            ST_ROWS: begin
                if (sel_any.hit) begin
                    n_valid = 1'b1;
                    n_kind  = KIND_ROW;
                    n_city  = sel_any.city;
                    n_state = sel_any.state;
                    n_total = sel_any.cases;
                    n_date  = sel_any.date;
                    n_last  = (r_emit + FILL_W'(1)) == r_count;
                    n_emit  = r_emit + FILL_W'(1);
                end
                if (tail.act) begin
                    n_fsm = ST_IDLE;
                end
            end
            default: begin
                n_fsm = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm    <= ST_IDLE;
            r_launch <= 1'b0;
            r_fill   <= '0;
            r_count  <= '0;
            r_emit   <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_fsm    <= n_fsm;
            r_launch <= n_launch;
            r_fill   <= n_fill;
            r_count  <= n_count;
            r_emit   <= n_emit;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req   <= n_req;
        r_kind  <= n_kind;
        r_city  <= n_city;
        r_state <= n_state;
        r_total <= n_total;
        r_date  <= n_date;
        r_last  <= n_last;
    end

    assign busy          = (r_fsm != ST_IDLE);
    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_out_city    = r_city;
    assign o_out_state   = r_state;
    assign o_case_total  = r_total;
    assign o_latest_date = r_date;
    assign o_last        = r_last;

`ifndef SYNTHESIS
    a_idle_no_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !tail.act)
        else $error("token still in the cell row while idle");

    a_last_then_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("result directly after the final result of a request");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(ENTRIES))
        else $error("fill count beyond table size");

    a_rows_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == ST_ROWS) |-> (r_emit <= r_count))
        else $error("more report rows than matches counted");

    a_row_only_in_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_ROW) |-> $past(r_fsm) == ST_ROWS)
        else $error("report row outside the row pass");
`endif

endmodule
